### src/pps_pkg.sv
// Shared types, constants and command/status structs for the polygon plane split block.
package pps_pkg;

   localparam int MAX_VERTS = 16;
   localparam int RES_CAP   = 48;
   localparam int ADDR_W    = $clog2(MAX_VERTS);
   localparam int CNT_W     = $clog2(MAX_VERTS + 1);
   localparam int RES_W     = $clog2(RES_CAP + 1);
   localparam int DIV_STEPS = 32;
   localparam int DIV_W     = $clog2(DIV_STEPS);

   localparam logic [2:0] CSR_NORMAL_X     = 3'd0;
   localparam logic [2:0] CSR_NORMAL_Y     = 3'd1;
   localparam logic [2:0] CSR_NORMAL_Z     = 3'd2;
   localparam logic [2:0] CSR_PLANE_OFFSET = 3'd3;
   localparam logic [2:0] CSR_TOLERANCE    = 3'd4;

   localparam logic [1:0] CLS_FRONT = 2'd0;
   localparam logic [1:0] CLS_BACK  = 2'd1;
   localparam logic [1:0] CLS_ON    = 2'd2;

   localparam logic [1:0] OUT_SPLIT = 2'd0;
   localparam logic [1:0] OUT_FRONT = 2'd1;
   localparam logic [1:0] OUT_BACK  = 2'd2;

   localparam logic [17:0] NORM_POS_ONE = 18'h10000;
   localparam logic [17:0] NORM_NEG_ONE = 18'h30000;

   typedef struct packed {
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
      logic               final_vertex;
   } req_type;

   typedef struct packed {
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] oz;
      logic               side_list;
      logic [1:0]         outcome;
      logic               overflow;
      logic               end_of_list;
      logic               end_of_run;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [51:0] plane_dist;
      logic [1:0]         cls;
   } entry_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LOADED,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_Z,
      ST_STORE,
      ST_EMIT_INIT,
      ST_W_READ,
      ST_W_PUSH,
      ST_S_READ_I,
      ST_S_READ_J,
      ST_S_CHECK,
      ST_DIVIDE,
      ST_C_MUL_X,
      ST_C_MUL_Y,
      ST_C_MUL_Z,
      ST_C_PUSH,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic              accept;
      logic              mark_overflow;
      logic              mul_x;
      logic              mul_y;
      logic              mul_z;
      logic              store;
      logic              begin_emit;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              latch_a;
      logic              latch_b;
      logic              div_step;
      logic              cmul_x;
      logic              cmul_y;
      logic              cmul_z;
      logic              push_read;
      logic              push_a;
      logic              push_cross;
      logic              set_back;
      logic              flush;
   } dp_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             full;
      logic             final_vertex;
      logic             nf_zero;
      logic             nb_zero;
      logic             side;
      logic             a_keep;
      logic             crossing;
   } dp_status_type;

endpackage

### src/pps_datapath.sv
// Datapath: config registers, distance unit, vertex store, divider, crossing unit, output stage.
module pps_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_wdata,
   input  pps_pkg::req_type       req_data,
   input  pps_pkg::dp_cmd_type    cmd,
   output pps_pkg::dp_status_type status,
   output logic                   rsp_valid,
   output pps_pkg::rsp_type       rsp_data
);
   import pps_pkg::*;

   logic signed [17:0] nx_ff, ny_ff, nz_ff;
   logic signed [31:0] off_ff;
   logic [30:0]        tol_ff;

   req_type            vin_ff;
   logic signed [17:0] mul_n;
   logic signed [31:0] mul_v;
   logic signed [49:0] dprod_in, dprod_ff;
   logic signed [51:0] acc_ff, dprod_ext, dist_now, tol_s, off_scaled;
   logic [1:0]         cls;

   entry_type          mem [MAX_VERTS];
   entry_type          rd_ff, a_ff, b_ff;
   logic [CNT_W-1:0]   cnt_ff, nf_ff, nb_ff;
   logic               overflow_ff;
   logic               side_ff;
   logic [1:0]         outcome_ff;

   logic [53:0]        rem_ff, rem2;
   logic [52:0]        den_ff;
   logic [31:0]        t_ff;
   logic [51:0]        mag_a, mag_b;

   logic signed [31:0] ca, cb;
   logic [32:0]        delta;
   logic [31:0]        cmag;
   logic [63:0]        cprod_in, cprod_ff;
   logic               cneg_ff;
   logic signed [31:0] cx_ff, cy_ff, cz;

   logic               push, take_new, emit_hold;
   rsp_type            new_rsp, hold_ff, emit_rsp;
   logic               hold_valid_ff, rsp_valid_ff;
   rsp_type            rsp_ff;
   logic [RES_W-1:0]   res_cnt_ff;

   function automatic logic [51:0] mag52(input logic signed [51:0] v);
      return v[51] ? 52'(-v) : 52'(v);
   endfunction

   // round half up on |delta|*t, then step from a toward b; axis normals snap
   function automatic logic signed [31:0] finish(
      input logic [63:0] prod, input logic neg, input logic signed [31:0] a,
      input logic [17:0] nrm, input logic signed [31:0] off);
      logic [64:0] r;
      logic [31:0] step;
      r    = {1'b0, prod} + 65'h80000000;
      step = r[63:32];
      if (nrm == NORM_POS_ONE) return off;
      if (nrm == NORM_NEG_ONE) return (off == 32'sh80000000) ? 32'sh7fffffff : -off;
      return neg ? a - $signed(step) : a + $signed(step);
   endfunction

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff  <= '0;
         ny_ff  <= '0;
         nz_ff  <= 18'sh10000;
         off_ff <= '0;
         tol_ff <= 31'd66;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NORMAL_X:     nx_ff  <= csr_wdata[17:0];
            CSR_NORMAL_Y:     ny_ff  <= csr_wdata[17:0];
            CSR_NORMAL_Z:     nz_ff  <= csr_wdata[17:0];
            CSR_PLANE_OFFSET: off_ff <= csr_wdata;
            CSR_TOLERANCE:    tol_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // distance: one product per cycle into the accumulator
   always_comb begin
      if (cmd.mul_z) begin
         mul_v = vin_ff.vz;
         mul_n = nz_ff;
      end else if (cmd.mul_y) begin
         mul_v = vin_ff.vy;
         mul_n = ny_ff;
      end else begin
         mul_v = vin_ff.vx;
         mul_n = nx_ff;
      end
   end

   assign dprod_in   = mul_v * mul_n;
   assign dprod_ext  = {{2{dprod_ff[49]}}, dprod_ff};
   assign off_scaled = {{4{off_ff[31]}}, off_ff, 16'b0};
   assign dist_now   = acc_ff + dprod_ext;
   assign tol_s      = $signed({5'b0, tol_ff, 16'b0});

   always_comb begin
      if (dist_now > tol_s) cls = CLS_FRONT;
      else if (dist_now < -tol_s) cls = CLS_BACK;
      else cls = CLS_ON;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) vin_ff <= req_data;
      if (cmd.mul_x || cmd.mul_y || cmd.mul_z) dprod_ff <= dprod_in;
      if (cmd.mul_x) acc_ff <= -off_scaled;
      else if (cmd.mul_y || cmd.mul_z) acc_ff <= acc_ff + dprod_ext;
   end

   // vertex store
   always_ff @(posedge clock) begin
      if (cmd.store)
         mem[cnt_ff[ADDR_W-1:0]] <= '{x: vin_ff.vx, y: vin_ff.vy, z: vin_ff.vz,
                                     plane_dist: dist_now, cls: cls};
      if (cmd.rd_en) rd_ff <= mem[cmd.rd_addr];
      if (cmd.latch_a) a_ff <= rd_ff;
      if (cmd.latch_b) b_ff <= rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         nf_ff       <= '0;
         nb_ff       <= '0;
         overflow_ff <= 1'b0;
         side_ff     <= 1'b0;
         outcome_ff  <= OUT_SPLIT;
      end else begin
         if (cmd.mark_overflow) overflow_ff <= 1'b1;
         if (cmd.store) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cls == CLS_FRONT) nf_ff <= nf_ff + 1'b1;
            if (cls == CLS_BACK)  nb_ff <= nb_ff + 1'b1;
         end
         if (cmd.begin_emit) begin
            side_ff <= (nf_ff == '0);
            if (nf_ff == '0) outcome_ff <= OUT_BACK;
            else if (nb_ff == '0) outcome_ff <= OUT_FRONT;
            else outcome_ff <= OUT_SPLIT;
         end
         if (cmd.set_back) side_ff <= 1'b1;
         if (cmd.flush) begin
            cnt_ff      <= '0;
            nf_ff       <= '0;
            nb_ff       <= '0;
            overflow_ff <= 1'b0;
         end
      end
   end

   // restoring divider, one quotient bit per cycle
   assign mag_a = mag52(a_ff.plane_dist);
   assign mag_b = mag52(rd_ff.plane_dist);
   assign rem2  = {rem_ff[52:0], 1'b0};

   always_ff @(posedge clock) begin
      if (cmd.latch_b) begin
         rem_ff <= {2'b0, mag_a};
         den_ff <= {1'b0, mag_a} + {1'b0, mag_b};
         t_ff   <= '0;
      end else if (cmd.div_step) begin
         if (rem2 >= {1'b0, den_ff}) begin
            rem_ff <= rem2 - {1'b0, den_ff};
            t_ff   <= {t_ff[30:0], 1'b1};
         end else begin
            rem_ff <= rem2;
            t_ff   <= {t_ff[30:0], 1'b0};
         end
      end
   end

   // crossing point: one coordinate product per cycle, finished the cycle after
   always_comb begin
      if (cmd.cmul_z) begin
         ca = a_ff.z;
         cb = b_ff.z;
      end else if (cmd.cmul_y) begin
         ca = a_ff.y;
         cb = b_ff.y;
      end else begin
         ca = a_ff.x;
         cb = b_ff.x;
      end
   end

   assign delta    = {cb[31], cb} - {ca[31], ca};
   assign cmag     = delta[32] ? 32'(-delta) : delta[31:0];
   assign cprod_in = cmag * t_ff;
   assign cz       = finish(cprod_ff, cneg_ff, a_ff.z, nz_ff, off_ff);

   always_ff @(posedge clock) begin
      if (cmd.cmul_x || cmd.cmul_y || cmd.cmul_z) begin
         cprod_ff <= cprod_in;
         cneg_ff  <= delta[32];
      end
      if (cmd.cmul_y) cx_ff <= finish(cprod_ff, cneg_ff, a_ff.x, nx_ff, off_ff);
      if (cmd.cmul_z) cy_ff <= finish(cprod_ff, cneg_ff, a_ff.y, ny_ff, off_ff);
   end

   // output stage: one result held back so the end markers are known
   assign push = cmd.push_read || cmd.push_a || cmd.push_cross;

   always_comb begin
      new_rsp = '0;
      if (cmd.push_cross) begin
         new_rsp.ox = cx_ff;
         new_rsp.oy = cy_ff;
         new_rsp.oz = cz;
      end else if (cmd.push_a) begin
         new_rsp.ox = a_ff.x;
         new_rsp.oy = a_ff.y;
         new_rsp.oz = a_ff.z;
      end else begin
         new_rsp.ox = rd_ff.x;
         new_rsp.oy = rd_ff.y;
         new_rsp.oz = rd_ff.z;
      end
      new_rsp.side_list = side_ff;
      new_rsp.outcome   = outcome_ff;
      new_rsp.overflow  = overflow_ff;

      take_new  = push && (res_cnt_ff < RES_W'(RES_CAP));
      emit_hold = hold_valid_ff && (take_new || cmd.flush);
      emit_rsp  = hold_ff;
      emit_rsp.end_of_list = cmd.flush || (hold_ff.side_list != new_rsp.side_list);
      emit_rsp.end_of_run  = cmd.flush;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         res_cnt_ff    <= '0;
      end else begin
         rsp_valid_ff <= emit_hold;
         if (cmd.begin_emit) res_cnt_ff <= '0;
         else if (take_new) res_cnt_ff <= res_cnt_ff + 1'b1;
         if (take_new) hold_valid_ff <= 1'b1;
         else if (cmd.flush) hold_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_new) hold_ff <= new_rsp;
      if (emit_hold) rsp_ff <= emit_rsp;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      status.count        = cnt_ff;
      status.full         = (cnt_ff == CNT_W'(MAX_VERTS));
      status.final_vertex = vin_ff.final_vertex;
      status.nf_zero      = (nf_ff == '0);
      status.nb_zero      = (nb_ff == '0);
      status.side         = side_ff;
      status.a_keep       = (a_ff.cls == CLS_ON) || (a_ff.cls == {1'b0, side_ff});
      status.crossing     = (a_ff.cls != CLS_ON) && (rd_ff.cls != CLS_ON)
                            && (rd_ff.cls != a_ff.cls);
   end

endmodule

### src/pps_ctrl.sv
// Controller: sequences vertex loading, the split walk over the store and the final flush.
module pps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  pps_pkg::dp_status_type status,
   output pps_pkg::dp_cmd_type    cmd
);
   import pps_pkg::*;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in, idx_next;
   logic [DIV_W-1:0]  div_cnt_ff, div_cnt_in;
   logic              last_idx;

   assign last_idx = (CNT_W'(idx_ff) + CNT_W'(1)) == status.count;
   assign idx_next = last_idx ? '0 : ADDR_W'(idx_ff + 1'b1);
   assign busy     = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         idx_ff     <= '0;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      div_cnt_in = div_cnt_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_LOADED;
         ST_LOADED: begin
            if (!status.full) state_in = ST_MUL_X;
            else if (status.final_vertex) state_in = ST_EMIT_INIT;
            else state_in = ST_IDLE;
         end
         ST_MUL_X:  state_in = ST_MUL_Y;
         ST_MUL_Y:  state_in = ST_MUL_Z;
         ST_MUL_Z:  state_in = ST_STORE;
         ST_STORE:  state_in = status.final_vertex ? ST_EMIT_INIT : ST_IDLE;
         ST_EMIT_INIT: begin
            idx_in   = '0;
            state_in = (status.nf_zero || status.nb_zero) ? ST_W_READ : ST_S_READ_I;
         end
         ST_W_READ: state_in = ST_W_PUSH;
         ST_W_PUSH: begin
            idx_in   = idx_next;
            state_in = last_idx ? ST_FLUSH : ST_W_READ;
         end
         ST_S_READ_I: state_in = ST_S_READ_J;
         ST_S_READ_J: state_in = ST_S_CHECK;
         ST_S_CHECK: begin
            div_cnt_in = '0;
            if (status.crossing) state_in = ST_DIVIDE;
            else begin
               idx_in   = idx_next;
               state_in = (last_idx && status.side) ? ST_FLUSH : ST_S_READ_I;
            end
         end
         ST_DIVIDE: begin
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_W'(DIV_STEPS - 1)) state_in = ST_C_MUL_X;
         end
         ST_C_MUL_X: state_in = ST_C_MUL_Y;
         ST_C_MUL_Y: state_in = ST_C_MUL_Z;
         ST_C_MUL_Z: state_in = ST_C_PUSH;
         ST_C_PUSH: begin
            idx_in   = idx_next;
            state_in = (last_idx && status.side) ? ST_FLUSH : ST_S_READ_I;
         end
         ST_FLUSH:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:   cmd.accept = start;
         ST_LOADED: cmd.mark_overflow = status.full;
         ST_MUL_X:  cmd.mul_x = 1'b1;
         ST_MUL_Y:  cmd.mul_y = 1'b1;
         ST_MUL_Z:  cmd.mul_z = 1'b1;
         ST_STORE:  cmd.store = 1'b1;
         ST_EMIT_INIT: cmd.begin_emit = 1'b1;
         ST_W_READ: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = idx_ff;
         end
         ST_W_PUSH: cmd.push_read = 1'b1;
         ST_S_READ_I: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = idx_ff;
         end
         ST_S_READ_J: begin
            cmd.latch_a = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = idx_next;
         end
         ST_S_CHECK: begin
            cmd.latch_b  = 1'b1;
            cmd.push_a   = status.a_keep;
            cmd.set_back = !status.crossing && last_idx && !status.side;
         end
         ST_DIVIDE:  cmd.div_step = 1'b1;
         ST_C_MUL_X: cmd.cmul_x = 1'b1;
         ST_C_MUL_Y: cmd.cmul_y = 1'b1;
         ST_C_MUL_Z: cmd.cmul_z = 1'b1;
         ST_C_PUSH: begin
            cmd.push_cross = 1'b1;
            cmd.set_back   = last_idx && !status.side;
         end
         ST_FLUSH:  cmd.flush = 1'b1;
         default: ;
      endcase
   end

endmodule

### src/polygon_plane_split.sv
// Top level of the polygon plane split block: controller plus datapath.
//
// Usage: a vertex request is taken when start is high and busy is low; a
// non-final vertex keeps busy high through a decode step, then 3
// shared-multiplier passes for the plane distance, then the store write,
// or only through the decode step once the 16-entry store is full and the
// vertex is dropped. The request that carries final_vertex starts the
// split, and busy stays high until the walk over the store ends (a setup
// step, the walk, a flush step). Whole-polygon output reads each vertex
// through the one store read port, registered, and then pushes it. A split
// walks the store once per side, and each crossing edge adds, per side, a
// bit-serial divide of the ratio, the per-coordinate multiplies and a push
// of the point. Results appear on rsp_data for one cycle with rsp_valid
// high and cannot be held off; one result is kept back internally so that
// end_of_list and end_of_run land on the right item, so the last one leaves
// in the same cycle as busy falls. No clearing pass is needed after reset.
module polygon_plane_split (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pps_pkg::req_type  req_data,
   output logic              rsp_valid,
   output pps_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import pps_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing: load, classify, walk, flush
   pps_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // arithmetic, store and the output register
   pps_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
